/* hdl/tksl_pkg.sv */
// Package for the top-k score list: widths, operation codes, the entry type
// and the per-cell control bundle. No dependencies.
package tksl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int RANK_W = 5;
  localparam int SCORE_W = 32;
  localparam int ID_W = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    logic   occupied;
    entry_t item;
  } cell_ctrl_t;

endpackage

/* hdl/tksl_req_if.sv */
// Request channel of the top-k score list: valid/ready plus operation and entry.
// Depends on tksl_pkg.
interface tksl_req_if;
  import tksl_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [ID_W-1:0]    entry_id;
  logic [SCORE_W-1:0] score;

  modport source (output valid, func, entry_id, score, input ready);
  modport sink (input valid, func, entry_id, score, output ready);

endinterface

/* hdl/tksl_rsp_if.sv */
// Response channel of the top-k score list: valid/ready plus placement report.
// Depends on tksl_pkg.
interface tksl_rsp_if;
  import tksl_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  rank;
  logic               kept;
  logic [RANK_W-1:0]  count;
  logic [ID_W-1:0]    best_id;
  logic [SCORE_W-1:0] best_score;

  modport source (output valid, rank, kept, count, best_id, best_score, input ready);
  modport sink (input valid, rank, kept, count, best_id, best_score, output ready);

endinterface

/* hdl/tksl_cell.sv */
// One slot of the sorted list: holds an entry, compares it with the incoming
// score and either holds, takes the new entry or takes its upper neighbor's.
// Depends on tksl_pkg.
module tksl_cell (
  input  logic                clk,
  input  tksl_pkg::cell_ctrl_t ctrl,
  input  tksl_pkg::entry_t    prev_entry,
  input  logic                prev_ge,
  output tksl_pkg::entry_t    entry,
  output logic                ge
);
  import tksl_pkg::*;

  entry_t entry_next;

  assign ge = !ctrl.occupied || (ctrl.item.score > entry.score);

  always_comb begin
    entry_next = entry;
    if (ctrl.wr_en) begin
      if (prev_ge) begin
        entry_next = prev_entry;
      end else if (ge) begin
        entry_next = ctrl.item;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* hdl/top_k_score_list.sv */
// Top level of the top-k score list: chain of compare/shift cells, count and
// capacity registers, and the registered response stage.
// Depends on tksl_pkg, tksl_req_if, tksl_rsp_if and tksl_cell.
//
// Usage:
//   req carries one beat per operation: func selects insert or clear, with
//   entry_id and score for an insert. rsp returns exactly one beat per
//   request: rank where the entry landed (MAX_ENTRIES when discarded), kept,
//   the count held afterwards and the best entry afterwards (zero if empty).
//   cfg_we/cfg_wdata write the capacity; write it only while the block idles.
//   Every cell compares the new score with its own entry in the same cycle,
//   so the response beat is registered in the cycle after the request beat
//   is taken; one request is taken per cycle while rsp.ready stays high.
//   The response register decouples the sides: req.ready stays high while
//   rsp is empty or being taken; a stalled response holds and blocks only
//   the next request.
//   Reset empties the list, sets capacity to 10 and drops any pending beat.
//   Entries are not cleared; the count alone marks which cells are held.
module top_k_score_list (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tksl_pkg::CAP_W-1:0] cfg_wdata,
  tksl_req_if.sink                   req,
  tksl_rsp_if.source                 rsp
);
  import tksl_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic             rsp_valid;
  logic             accept;
  logic             insert;
  logic             full;
  logic             kept;
  logic [CMP_W-1:0] cap_c;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] rank_w;
  entry_t           new_item;
  entry_t           best;

  entry_t           entries [MAX_ENTRIES];
  logic             ge [MAX_ENTRIES];
  cell_ctrl_t       ctrl [MAX_ENTRIES];

  assign accept   = req.valid && req.ready;
  assign insert   = (req.func == FUNC_INSERT);
  assign new_item = '{score: req.score, id: req.entry_id};

  assign cap_c = (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) ?
                 CMP_W'(MAX_ENTRIES) : CMP_W'(capacity);
  assign full  = CMP_W'(held) >= cap_c;

  always_comb begin
    pos = CNT_W'(MAX_ENTRIES);
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (ge[i]) begin
        pos = CNT_W'(i);
      end
    end
  end

  assign kept   = insert && (!full || (pos < held));
  assign rank_w = kept ? pos : CNT_W'(MAX_ENTRIES);

  always_comb begin
    held_next = held;
    if (!insert) begin
      held_next = '0;
    end else if (kept && !full) begin
      held_next = held + CNT_W'(1);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      assign ctrl[g] = '{wr_en: accept && kept,
                         occupied: (CNT_W'(g) < held),
                         item: new_item};
      if (g == 0) begin : g_head
        tksl_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl[g]),
          .prev_entry (new_item),
          .prev_ge    (1'b0),
          .entry      (entries[g]),
          .ge         (ge[g])
        );
      end else begin : g_body
        tksl_cell u_cell (
          .clk        (clk),
          .ctrl       (ctrl[g]),
          .prev_entry (entries[g-1]),
          .prev_ge    (ge[g-1]),
          .entry      (entries[g]),
          .ge         (ge[g])
        );
      end
    end
  endgenerate

  always_comb begin
    if (held_next == '0) begin
      best = '0;
    end else if (kept && (pos == '0)) begin
      best = new_item;
    end else begin
      best = entries[0];
    end
  end

  assign req.ready = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        held      <= held_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // capture the response beat
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.rank       <= RANK_W'(rank_w);
      rsp.kept       <= kept;
      rsp.count      <= RANK_W'(held_next);
      rsp.best_id    <= best.id;
      rsp.best_score <= best.score;
    end
  end

endmodule
